// ----- hdl/wht_pkg.sv -----
package wht_pkg;

    // Default build values
    localparam int MAX_WINDOWS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;

    // Request opcodes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_HIT    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SHELL_EN   = 2'd0;
    localparam logic [1:0] REG_SHELL_SLOT = 2'd1;
    localparam logic [1:0] REG_EXP_MASK   = 2'd2;

    // Request class after decode
    typedef enum logic [1:0] {
        K_CREATE = 2'd0,
        K_UPDATE = 2'd1,
        K_HIT    = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    // Head of the request queue as seen by the execution side
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [3:0] slot;
    } t_cmd_ctl;

    // One result transaction
    typedef struct packed {
        logic       done;
        logic [1:0] status;
        logic [3:0] slot;
        logic       found;
        logic       area;
    } t_result;

    // Configuration register file contents
    typedef struct packed {
        logic        shell_en;
        logic [3:0]  shell_slot;
        logic [15:0] exp_mask;
    } t_cfg;

endpackage

// ----- hdl/wht_front.sv -----
module wht_front import wht_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_opcode,
    input  logic [3:0]                i_slot,
    input  logic [8*COORD_BITS-1:0]   i_geom,
    input  logic [2*COORD_BITS-1:0]   i_point,
    output t_cmd_ctl                  o_ctl,
    output logic [8*COORD_BITS-1:0]   o_geom,
    output logic [2*COORD_BITS-1:0]   o_point,
    input  logic                      i_pop
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    t_kind                    r_kind_q  [Q_DEPTH];
    logic [3:0]               r_slot_q  [Q_DEPTH];
    logic [8*COORD_BITS-1:0]  r_geom_q  [Q_DEPTH];
    logic [2*COORD_BITS-1:0]  r_point_q [Q_DEPTH];
    logic [PTR_W-1:0]         r_wptr;
    logic [PTR_W-1:0]         r_rptr;
    logic [PTR_W:0]           r_level;
    t_kind                    kind;
    logic                     push;

    // Classify the incoming opcode
    always_comb begin
        unique case (i_opcode)
            OP_CREATE: kind = K_CREATE;
            OP_UPDATE: kind = K_UPDATE;
            OP_HIT:    kind = K_HIT;
            default:   kind = K_NONE;
        endcase
    end

    assign o_busy = (r_level == (PTR_W+1)'(Q_DEPTH));
    assign push   = i_start && !o_busy;

    // Store the accepted transaction
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind_q[r_wptr]  <= kind;
            r_slot_q[r_wptr]  <= i_slot;
            r_geom_q[r_wptr]  <= i_geom;
            r_point_q[r_wptr] <= i_point;
        end
    end

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    // Present the queue head
    assign o_ctl.valid = (r_level != '0);
    assign o_ctl.kind  = r_kind_q[r_rptr];
    assign o_ctl.slot  = r_slot_q[r_rptr];
    assign o_geom      = r_geom_q[r_rptr];
    assign o_point     = r_point_q[r_rptr];

endmodule

// ----- hdl/wht_back.sv -----
module wht_back import wht_pkg::*; #(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_cmd_ctl                  i_ctl,
    input  logic [8*COORD_BITS-1:0]   i_geom,
    input  logic [2*COORD_BITS-1:0]   i_point,
    output logic                      o_pop,
    output t_result                   o_res
);

    localparam int IDX_W = $clog2(MAX_WINDOWS);
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int SUM_W = COORD_BITS + 2;
    localparam logic [EXT_W-1:0] MAX_EXT    = EXT_W'(MAX_WINDOWS);
    localparam logic [EXT_W-1:0] MASK_SLOTS = EXT_W'(16);

    typedef struct packed {
        logic [COORD_BITS-1:0] f_left;
        logic [COORD_BITS-1:0] f_top;
        logic [COORD_BITS-1:0] f_width;
        logic [COORD_BITS-1:0] f_height;
        logic [COORD_BITS-1:0] c_left;
        logic [COORD_BITS-1:0] c_top;
        logic [COORD_BITS-1:0] c_width;
        logic [COORD_BITS-1:0] c_height;
    } t_geom;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHELL = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_chk, n_chk;
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic                  r_found, n_found;
    logic [IDX_W-1:0]      r_win, n_win;
    logic                  r_area, n_area;
    t_result               r_res, n_res;

    t_geom                 r_mem [MAX_WINDOWS];
    t_geom                 r_rdata;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    t_geom                 mem_wdata;
    logic [IDX_W-1:0]      rd_addr;

    t_geom                 cmd_geom;
    logic [EXT_W-1:0]      count_ext, slot_ext, shell_ext, chk_ext, win_ext;
    logic [SUM_W-1:0]      px_s, py_s;
    logic [SUM_W-1:0]      fr_l, fr_t, fr_r, fr_b;
    logic [SUM_W-1:0]      cl_l, cl_t, cl_r, cl_b;
    logic                  in_frame, in_client, expanded;
    logic                  sel_found, sel_area;
    logic [IDX_W-1:0]      sel_win;

    assign cmd_geom  = i_geom;
    assign count_ext = EXT_W'(r_count);
    assign slot_ext  = EXT_W'(i_ctl.slot);
    assign shell_ext = EXT_W'(i_cfg.shell_slot);
    assign chk_ext   = EXT_W'(r_chk);

    // Geometry table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Bound checks on the entry read last cycle
    always_comb begin
        px_s = SUM_W'(r_px);
        py_s = SUM_W'(r_py);
        fr_l = SUM_W'(r_rdata.f_left);
        fr_t = SUM_W'(r_rdata.f_top);
        fr_r = fr_l + SUM_W'(r_rdata.f_width);
        fr_b = fr_t + SUM_W'(r_rdata.f_height);
        cl_l = fr_l + SUM_W'(r_rdata.c_left);
        cl_t = fr_t + SUM_W'(r_rdata.c_top);
        cl_r = cl_l + SUM_W'(r_rdata.c_width);
        cl_b = cl_t + SUM_W'(r_rdata.c_height);
        in_frame  = (px_s >= fr_l) && (px_s <= fr_r) && (py_s >= fr_t) && (py_s <= fr_b);
        in_client = (px_s >= cl_l) && (px_s <= cl_r) && (py_s >= cl_t) && (py_s <= cl_b);
        expanded  = (chk_ext < MASK_SLOTS) && i_cfg.exp_mask[chk_ext[3:0]];
    end

    // Running winner of the scan, including the entry checked now
    always_comb begin
        sel_found = r_found || in_frame;
        sel_win   = in_frame ? r_chk : r_win;
        sel_area  = in_frame ? (in_client && !expanded) : r_area;
        win_ext   = EXT_W'(sel_win);
    end

    // Sequencer for create, update and hit-test transactions
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_chk     = r_chk;
        n_px      = r_px;
        n_py      = r_py;
        n_found   = r_found;
        n_win     = r_win;
        n_area    = r_area;
        n_res     = '0;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = count_ext[IDX_W-1:0];
        mem_wdata = cmd_geom;
        rd_addr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.valid) begin
                    o_pop      = 1'b1;
                    n_res.done = 1'b1;
                    unique case (i_ctl.kind)
                        K_CREATE: begin
                            if (count_ext < MAX_EXT) begin
                                mem_we             = 1'b1;
                                mem_waddr          = count_ext[IDX_W-1:0];
                                mem_wdata.c_left   = '0;
                                mem_wdata.c_top    = '0;
                                mem_wdata.c_width  = cmd_geom.f_width;
                                mem_wdata.c_height = cmd_geom.f_height;
                                n_res.slot         = count_ext[3:0];
                                n_count            = r_count + 1'b1;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        K_UPDATE: begin
                            if (slot_ext < count_ext) begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_ext[IDX_W-1:0];
                            end else begin
                                n_res.status = ST_NO_SLOT;
                            end
                        end
                        K_HIT: begin
                            n_px    = i_point[2*COORD_BITS-1:COORD_BITS];
                            n_py    = i_point[COORD_BITS-1:0];
                            n_found = 1'b0;
                            n_win   = '0;
                            n_area  = 1'b0;
                            if (i_cfg.shell_en && (shell_ext < count_ext)) begin
                                rd_addr    = shell_ext[IDX_W-1:0];
                                n_res.done = 1'b0;
                                n_state    = S_SHELL;
                            end else if (r_count != '0) begin
                                rd_addr    = '0;
                                n_chk      = '0;
                                n_res.done = 1'b0;
                                n_state    = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHELL: begin
                if (in_frame) begin
                    n_res.done  = 1'b1;
                    n_res.slot  = i_cfg.shell_slot;
                    n_res.found = 1'b1;
                    n_res.area  = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    rd_addr = '0;
                    n_chk   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_found = sel_found;
                n_win   = sel_win;
                n_area  = sel_area;
                if ((chk_ext + EXT_W'(1)) == count_ext) begin
                    n_res.done = 1'b1;
                    if (sel_found) begin
                        n_res.slot  = win_ext[3:0];
                        n_res.found = 1'b1;
                        n_res.area  = sel_area;
                    end
                    n_state = S_IDLE;
                end else begin
                    rd_addr = r_chk + 1'b1;
                    n_chk   = r_chk + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_res   <= n_res;
        end
    end

    // Hold scan payload
    always_ff @(posedge i_clk) begin
        r_chk   <= n_chk;
        r_px    <= n_px;
        r_py    <= n_py;
        r_found <= n_found;
        r_win   <= n_win;
        r_area  <= n_area;
    end

    assign o_res = r_res;

endmodule

// ----- hdl/window_hit_test_table_core.sv -----
// Window table with hit testing. A transaction is taken when start is high and busy is low;
// up to two requests wait in a queue while the execution unit works. Every request gives
// exactly one result, shown for one cycle with o_done high; the receiver cannot stall, so it
// must take each result in that cycle. Create and update report their result in the cycle after
// leaving the queue. A hit test reads the geometry table one entry per cycle through its single
// registered read port, checking an enabled shell window first. The user must write the
// configuration registers through the APB port only while no request is outstanding; the
// block itself does not enforce this.
module window_hit_test_table_core import wht_pkg::*; #(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_opcode,
    input  logic [3:0]            i_slot,
    input  logic [COORD_BITS-1:0] i_frame_left,
    input  logic [COORD_BITS-1:0] i_frame_top,
    input  logic [COORD_BITS-1:0] i_frame_width,
    input  logic [COORD_BITS-1:0] i_frame_height,
    input  logic [COORD_BITS-1:0] i_client_left,
    input  logic [COORD_BITS-1:0] i_client_top,
    input  logic [COORD_BITS-1:0] i_client_width,
    input  logic [COORD_BITS-1:0] i_client_height,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [3:0]            o_result_slot,
    output logic                  o_hover_found,
    output logic                  o_hit_area,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                    r_shell_en;
    logic [3:0]              r_shell_slot;
    logic [15:0]             r_exp_mask;
    logic                    cfg_wr;
    t_cfg                    cfg;
    t_cmd_ctl                q_ctl;
    logic [8*COORD_BITS-1:0] q_geom;
    logic [2*COORD_BITS-1:0] q_point;
    logic                    q_pop;
    t_result                 res;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shell_en   <= 1'b0;
            r_shell_slot <= '0;
            r_exp_mask   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SHELL_EN:   r_shell_en   <= pwdata[0];
                REG_SHELL_SLOT: r_shell_slot <= pwdata[3:0];
                REG_EXP_MASK:   r_exp_mask   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_SHELL_EN:   prdata = {31'd0, r_shell_en};
            REG_SHELL_SLOT: prdata = {28'd0, r_shell_slot};
            REG_EXP_MASK:   prdata = {16'd0, r_exp_mask};
            default:        prdata = '0;
        endcase
    end

    assign cfg.shell_en   = r_shell_en;
    assign cfg.shell_slot = r_shell_slot;
    assign cfg.exp_mask   = r_exp_mask;

    // Request decode and queue
    wht_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_opcode (i_opcode),
        .i_slot   (i_slot),
        .i_geom   ({i_frame_left, i_frame_top, i_frame_width, i_frame_height,
                    i_client_left, i_client_top, i_client_width, i_client_height}),
        .i_point  ({i_point_x, i_point_y}),
        .o_ctl    (q_ctl),
        .o_geom   (q_geom),
        .o_point  (q_point),
        .i_pop    (q_pop)
    );

    // Table and scan unit
    wht_back #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (q_ctl),
        .i_geom  (q_geom),
        .i_point (q_point),
        .o_pop   (q_pop),
        .o_res   (res)
    );

    assign o_done        = res.done;
    assign o_status      = res.status;
    assign o_result_slot = res.slot;
    assign o_hover_found = res.found;
    assign o_hit_area    = res.area;

endmodule
